>>> sv/lage_pkg.sv
package lage_pkg;

	// Depth of the exp(-t) table; t covers [0, 16).
	localparam int EXP_TABLE_DEPTH = 1024;
	localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
	localparam int DEP_W   = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int ENTRY_W = 17;

	// Gaussian argument: quotient bits kept, and the cut-off at 6.0.
	localparam int A_W       = 19;
	localparam int SQ_W      = 2 * A_W;
	localparam int PROD_W    = SQ_W + DEP_W;
	localparam int EXP_SHIFT = 37;
	localparam logic [A_W-1:0] A_LIMIT = A_W'(6 << 16);

	// Lorentz quotient: 41 bits, clamped to 2^40.
	localparam int LQ_W = 41;
	localparam logic [LQ_W-1:0] LOR_CLAMP = LQ_W'(64'd1 << 40);

	// Divider depths: one overflow check stage plus one stage per quotient bit.
	localparam int LDIV_N = LQ_W + 1;
	localparam int GDIV_N = A_W + 1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_LORENTZ_HEIGHT = 3'd0,
		REG_LORENTZ_WIDTH  = 3'd1,
		REG_LORENTZ_CENTER = 3'd2,
		REG_BASELINE       = 3'd3,
		REG_GAUSS_HEIGHT   = 3'd4,
		REG_GAUSS_CENTER   = 3'd5,
		REG_RIGHT_WIDTH    = 3'd6,
		REG_LEFT_WIDTH     = 3'd7
	} cfg_reg_t;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef logic [ENTRY_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

	// Magnitude of a 33-bit signed value that is known to fit 32 bits.
	function automatic logic [31:0] mag33(logic signed [32:0] v);
		logic [32:0] n;
		n = v[32] ? 33'(-v) : 33'(v);
		return n[31:0];
	endfunction

	// Division of a series term by its small step number.
	function automatic longint unsigned div_step(longint unsigned v, int i);
		case (i)
			1:       return v;
			2:       return v / 64'd2;
			3:       return v / 64'd3;
			4:       return v / 64'd4;
			5:       return v / 64'd5;
			6:       return v / 64'd6;
			7:       return v / 64'd7;
			8:       return v / 64'd8;
			9:       return v / 64'd9;
			10:      return v / 64'd10;
			11:      return v / 64'd11;
			12:      return v / 64'd12;
			13:      return v / 64'd13;
			14:      return v / 64'd14;
			default: return v;
		endcase
	endfunction

	// Entry k holds exp(-16k/depth) in Q16.16: Taylor series of exp(-t/16) in
	// Q2.30, then four squarings, then rounding to Q16.16.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		longint unsigned u;
		longint unsigned term;
		longint unsigned y;
		longint sum;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			u = (longint'(k) << 30) / EXP_TABLE_DEPTH;
			term = 64'd1 << 30;
			sum = longint'(64'd1 << 30);
			for (int i = 1; i <= 14; i++) begin
				term = div_step((term * u) >> 30, i);
				if ((i & 1) != 0) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			y = (sum < 0) ? 64'd0 : longint'(sum);
			for (int i = 0; i < 4; i++) begin
				y = (y * y + (64'd1 << 29)) >> 30;
			end
			tab[k] = ENTRY_W'((y + 64'd8192) >> 14);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> sv/lage_exp_rom.sv
module lage_exp_rom (
	input  logic                              clk,
	input  logic                              en,
	input  logic [lage_pkg::IDX_W-1:0]        addr,
	output logic [lage_pkg::ENTRY_W-1:0]      data
);

	// Registered read of the constant exp(-t) table.
	always_ff @(posedge clk) begin
		if (en) begin
			data <= lage_pkg::EXP_TAB[addr];
		end
	end

endmodule

>>> sv/lorentz_asym_gaussian_eval.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     sample_position
// result    out        out_valid / out_ready   model_value, saturated
// config    in         cfg_we (no wait)        cfg_index, cfg_wdata
//
// One item enters per cycle whenever the pipeline advances.
// The depth is set by the Lorentz divider, one quotient bit per stage.
// The whole pipeline advances together whenever the output register is
// empty or its result is taken; otherwise every stage holds.
// Reset clears the valid bits and loads the register reset values.
module lorentz_asym_gaussian_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sample_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] model_value,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata
);

	localparam int LN = lage_pkg::LDIV_N;
	localparam int GN = lage_pkg::GDIV_N;
	localparam int AW = lage_pkg::A_W;
	localparam int QW = lage_pkg::LQ_W;

	logic signed [31:0] lorentz_height_q, lorentz_width_q, lorentz_center_q, baseline_q;
	logic signed [31:0] gauss_height_q, gauss_center_q, right_width_q, left_width_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lorentz_height_q <= '0;
			lorentz_width_q  <= lage_pkg::ONE_Q16;
			lorentz_center_q <= '0;
			baseline_q       <= '0;
			gauss_height_q   <= '0;
			gauss_center_q   <= '0;
			right_width_q    <= lage_pkg::ONE_Q16;
			left_width_q     <= lage_pkg::ONE_Q16;
		end else if (cfg_we) begin
			case (lage_pkg::cfg_reg_t'(cfg_index))
				lage_pkg::REG_LORENTZ_HEIGHT: lorentz_height_q <= cfg_wdata;
				lage_pkg::REG_LORENTZ_WIDTH:  lorentz_width_q  <= cfg_wdata;
				lage_pkg::REG_LORENTZ_CENTER: lorentz_center_q <= cfg_wdata;
				lage_pkg::REG_BASELINE:       baseline_q       <= cfg_wdata;
				lage_pkg::REG_GAUSS_HEIGHT:   gauss_height_q   <= cfg_wdata;
				lage_pkg::REG_GAUSS_CENTER:   gauss_center_q   <= cfg_wdata;
				lage_pkg::REG_RIGHT_WIDTH:    right_width_q    <= cfg_wdata;
				lage_pkg::REG_LEFT_WIDTH:     left_width_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Global advance: the output register is free or being emptied.
	logic en;
	logic vld_s46;
	assign en       = !vld_s46 || out_ready;
	assign in_ready = en;

	// Stage 1: differences, magnitudes and the width choice.
	logic signed [32:0] ld_diff, gd_diff;
	logic signed [31:0] sig_sel;
	logic               vld_s1, zf_s1, gnz_s1;
	logic [31:0]        dm_s1, lwm_s1, gdm_s1, sigm_s1;

	assign ld_diff = 33'(sample_position) - 33'(lorentz_center_q);
	assign gd_diff = 33'(sample_position) - 33'(gauss_center_q);
	assign sig_sel = gd_diff[32] ? left_width_q : right_width_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s1   <= lage_pkg::mag33(ld_diff);
			lwm_s1  <= lage_pkg::mag33(33'(lorentz_width_q));
			gdm_s1  <= lage_pkg::mag33(gd_diff);
			sigm_s1 <= lage_pkg::mag33(33'(sig_sel));
			gnz_s1  <= (sig_sel != 32'sd0);
			zf_s1   <= (lorentz_width_q == 32'sd0) && (sample_position == lorentz_center_q);
		end
	end

	// Stage 2: the two squares of the Lorentz denominator.
	logic        vld_s2, zf_s2, gnz_s2;
	logic [63:0] w2_s2, d2_s2;
	logic [47:0] gnum_s2;
	logic [31:0] sigm_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			w2_s2   <= 64'(lwm_s1) * 64'(lwm_s1);
			d2_s2   <= 64'(dm_s1) * 64'(dm_s1);
			gnum_s2 <= {gdm_s1, 16'h0000};
			sigm_s2 <= sigm_s1;
			gnz_s2  <= gnz_s1;
			zf_s2   <= zf_s1;
		end
	end

	// Stage 3: denominator sum and Lorentz numerator.
	logic        vld_s3, zf_s3, gnz_s3;
	logic [64:0] dq_s3;
	logic [63:0] lnum_s3;
	logic [47:0] gnum_s3;
	logic [31:0] sigm_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s3   <= 65'(w2_s2) + 65'(d2_s2);
			lnum_s3 <= {lage_pkg::mag33(33'(lorentz_height_q)), 32'h0000_0000};
			gnum_s3 <= gnum_s2;
			sigm_s3 <= sigm_s2;
			gnz_s3  <= gnz_s2;
			zf_s3   <= zf_s2;
		end
	end

	// Divider stages: index k of the _sk arrays is pipeline stage 4+k.
	logic          vld_sk  [0:LN-1];
	logic          zf_sk   [0:LN-1];
	logic [63:0]   lrem_sk [0:LN-1];
	logic [64:0]   ldq_sk  [0:LN-1];
	logic [QW-1:0] lq_sk   [0:LN-1];
	logic          lovf_sk [0:LN-1];
	logic [47:0]   grem_sk [0:GN-1];
	logic [31:0]   gsig_sk [0:GN-1];
	logic [AW-1:0] gq_sk   [0:GN-1];
	logic          gen_sk  [0:GN-1];

	// First divider stage: quotients too large for their fields are flagged.
	always_ff @(posedge clk) begin
		if (en) begin
			lrem_sk[0] <= lnum_s3;
			ldq_sk[0]  <= dq_s3;
			lq_sk[0]   <= '0;
			lovf_sk[0] <= (65'(lnum_s3 >> QW) >= dq_s3);
			zf_sk[0]   <= zf_s3;
			grem_sk[0] <= gnum_s3;
			gsig_sk[0] <= sigm_s3;
			gq_sk[0]   <= '0;
			gen_sk[0]  <= gnz_s3 && ((gnum_s3 >> AW) < 48'(sigm_s3));
		end
	end

	// Valid bits through all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_sk[0] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_sk[0] <= vld_s3;
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar k = 1; k < LN; k++) begin : g_ldiv
		localparam int J = LN - 1 - k;
		logic lge;
		assign lge = (65'(lrem_sk[k-1] >> J) >= ldq_sk[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				lrem_sk[k] <= lge ? (lrem_sk[k-1] - (ldq_sk[k-1][63:0] << J)) : lrem_sk[k-1];
				ldq_sk[k]  <= ldq_sk[k-1];
				lq_sk[k]   <= {lq_sk[k-1][QW-2:0], lge};
				lovf_sk[k] <= lovf_sk[k-1];
				zf_sk[k]   <= zf_sk[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_sk[k-1];
			end
		end
	end

	for (genvar k = 1; k < GN; k++) begin : g_gdiv
		localparam int J = GN - 1 - k;
		logic gge;
		assign gge = ((grem_sk[k-1] >> J) >= 48'(gsig_sk[k-1]));

		always_ff @(posedge clk) begin
			if (en) begin
				grem_sk[k] <= gge ? (grem_sk[k-1] - (48'(gsig_sk[k-1]) << J)) : grem_sk[k-1];
				gsig_sk[k] <= gsig_sk[k-1];
				gq_sk[k]   <= {gq_sk[k-1][AW-2:0], gge};
				gen_sk[k]  <= gen_sk[k-1];
			end
		end
	end

	// Stage 24: range check on the argument and its square.
	logic [lage_pkg::SQ_W-1:0] sq_s24;
	logic                      aok_s24;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s24  <= lage_pkg::SQ_W'(gq_sk[GN-1]) * lage_pkg::SQ_W'(gq_sk[GN-1]);
			aok_s24 <= gen_sk[GN-1] && (gq_sk[GN-1] < lage_pkg::A_LIMIT);
		end
	end

	// Stage 25: table index from the scaled square.
	logic [lage_pkg::PROD_W-1:0]                    gprod;
	logic [lage_pkg::PROD_W-lage_pkg::EXP_SHIFT-1:0] idx_full;
	logic [lage_pkg::IDX_W-1:0]                     idx_s25;
	logic                                           gok_s25;

	assign gprod    = lage_pkg::PROD_W'(sq_s24) * lage_pkg::PROD_W'(lage_pkg::EXP_TABLE_DEPTH);
	assign idx_full = gprod[lage_pkg::PROD_W-1:lage_pkg::EXP_SHIFT];

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s25 <= idx_full[lage_pkg::IDX_W-1:0];
			gok_s25 <= aok_s24 && (idx_full <
				(lage_pkg::PROD_W-lage_pkg::EXP_SHIFT)'(lage_pkg::EXP_TABLE_DEPTH));
		end
	end

	// Stage 26: table read.
	logic [lage_pkg::ENTRY_W-1:0] entry_s26;
	logic                         gok_s26;

	lage_exp_rom u_exp_rom (
		.clk  (clk),
		.en   (en),
		.addr (idx_s25),
		.data (entry_s26)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			gok_s26 <= gok_s25;
		end
	end

	// Stage 27: scale by the Gaussian height and apply its sign.
	logic [48:0]        gmul;
	logic [32:0]        gmag;
	logic signed [33:0] gau_s27;

	assign gmul = 49'(lage_pkg::mag33(33'(gauss_height_q))) * 49'(entry_s26);
	assign gmag = gmul[48:16];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!gok_s26) begin
				gau_s27 <= '0;
			end else if (gauss_height_q[31]) begin
				gau_s27 <= -34'(gmag);
			end else begin
				gau_s27 <= 34'(gmag);
			end
		end
	end

	// Gaussian term waits for the Lorentz divider; index k is stage 4+k.
	localparam int GT_K = GN + 5;
	logic signed [33:0] gau_sk [GT_K-1:LN-1];

	always_ff @(posedge clk) begin
		if (en) begin
			gau_sk[GT_K-1] <= gau_s27;
		end
	end

	for (genvar k = GT_K; k < LN; k++) begin : g_gdly
		always_ff @(posedge clk) begin
			if (en) begin
				gau_sk[k] <= gau_sk[k-1];
			end
		end
	end

	// Stage 46: Lorentz clamp and sign, sum and saturation.
	logic [QW-1:0]      lmag;
	logic signed [41:0] lor, total;
	logic signed [31:0] value_s46;
	logic               sat_s46, zf_s46;

	assign lmag  = (lovf_sk[LN-1] || (lq_sk[LN-1] > lage_pkg::LOR_CLAMP)) ?
		lage_pkg::LOR_CLAMP : lq_sk[LN-1];
	assign lor   = lorentz_height_q[31] ? -42'(lmag) : 42'(lmag);
	assign total = 42'(baseline_q) + lor + 42'(gau_sk[LN-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			zf_s46 <= zf_sk[LN-1];
			if (zf_sk[LN-1]) begin
				value_s46 <= lorentz_height_q[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				sat_s46   <= 1'b1;
			end else if (total > 42'sh0_7FFF_FFFF) begin
				value_s46 <= 32'sh7FFF_FFFF;
				sat_s46   <= 1'b1;
			end else if (total < -42'sh0_8000_0000) begin
				value_s46 <= 32'sh8000_0000;
				sat_s46   <= 1'b1;
			end else begin
				value_s46 <= total[31:0];
				sat_s46   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s46 <= 1'b0;
		end else if (en) begin
			vld_s46 <= vld_sk[LN-1];
		end
	end

	assign out_valid   = vld_s46;
	assign model_value = value_s46;
	assign saturated   = sat_s46;

`ifndef SYNTHESIS
	// A valid bit moves one stage on every advance.
	a_vld_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (vld_s2 == $past(vld_s1)))
		else $error("valid bit lost or invented between stages 1 and 2");

	// A waiting result holds while the pipeline is stalled.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(model_value) && $stable(saturated) && out_valid))
		else $error("result changed during stall");

	// A zero denominator always reports saturation.
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zf_s46) |-> saturated)
		else $error("zero denominator without saturation flag");

	// Saturation without a zero denominator means a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated && !zf_s46) |->
		((model_value == 32'sh7FFF_FFFF) || (model_value == 32'sh8000_0000)))
		else $error("saturated result not at a range limit");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic signed [31:0] value;
		logic               sat;
	} model_out_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_TYPED} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		lage_pkg::cfg_reg_t idx;
		logic [31:0]        data;
		model_out_t         want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] sample_position;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] model_value;
	logic               saturated;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_wdata;

	// Mirror of the configuration registers and our own exp(-t) table.
	logic signed [31:0] regs_m [8];
	logic [31:0]        exp_lut [lage_pkg::EXP_TABLE_DEPTH];

	model_out_t pending_results[$];
	int         error_count;
	int         sent_count;
	int         rx_count;
	int         sat_count;
	int         gauss_hits;
	bit         hold_done;

	lorentz_asym_gaussian_eval dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample_position(sample_position),
		.out_valid(out_valid), .out_ready(out_ready),
		.model_value(model_value), .saturated(saturated),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Evaluate the peak model for one sample position from the register mirror.
	function automatic model_out_t eval_peak(logic signed [31:0] x);
		model_out_t r;
		logic signed [32:0] dl, dg;
		logic [32:0] dm, gm;
		logic [31:0] lwm, lhm, ghm, sm;
		logic signed [31:0] sig;
		logic signed [31:0] lh, lw, lc, gc;
		logic [63:0] w2, d2, q, a, idx, p;
		logic [64:0] dq;
		longint lor, gau, total;
		lor = 0;
		gau = 0;
		r.sat = 1'b0;
		lh = regs_m[lage_pkg::REG_LORENTZ_HEIGHT];
		lw = regs_m[lage_pkg::REG_LORENTZ_WIDTH];
		lc = regs_m[lage_pkg::REG_LORENTZ_CENTER];
		gc = regs_m[lage_pkg::REG_GAUSS_CENTER];
		// Lorentz term on an exact 33-bit distance.
		dl = {x[31], x} - {lc[31], lc};
		dm = dl[32] ? -dl : dl;
		lwm = lw[31] ? -lw : lw;
		lhm = lh[31] ? -lh : lh;
		w2 = 64'(lwm) * 64'(lwm);
		d2 = 64'(dm) * 64'(dm);
		if (w2 == 64'd0 && d2 == 64'd0) begin
			r.value = lh[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			r.sat = 1'b1;
			return r;
		end
		dq = 65'(w2) + 65'(d2);
		if (!dq[64]) begin
			q = (64'(lhm) << 32) / dq[63:0];
			if (q > (64'd1 << 40))
				q = 64'd1 << 40;
			lor = lh[31] ? -longint'(q) : longint'(q);
		end
		// Split Gaussian: right width at or above the center, left width below.
		dg = {x[31], x} - {gc[31], gc};
		sig = dg[32] ? regs_m[lage_pkg::REG_LEFT_WIDTH] : regs_m[lage_pkg::REG_RIGHT_WIDTH];
		if (sig != 0) begin
			gm = dg[32] ? -dg : dg;
			sm = sig[31] ? -sig : sig;
			a = (64'(gm) << 16) / 64'(sm);
			if (a < (64'd6 << 16)) begin
				idx = (a * a * 64'(lage_pkg::EXP_TABLE_DEPTH)) >> 37;
				if (idx < 64'(lage_pkg::EXP_TABLE_DEPTH)) begin
					ghm = regs_m[lage_pkg::REG_GAUSS_HEIGHT][31]
						? -regs_m[lage_pkg::REG_GAUSS_HEIGHT]
						: regs_m[lage_pkg::REG_GAUSS_HEIGHT];
					p = (64'(ghm) * 64'(exp_lut[idx])) >> 16;
					gau = regs_m[lage_pkg::REG_GAUSS_HEIGHT][31] ? -longint'(p)
						: longint'(p);
				end
			end
		end
		total = longint'(regs_m[lage_pkg::REG_BASELINE]) + lor + gau;
		if (total > 64'sd2147483647) begin
			total = 64'sd2147483647;
			r.sat = 1'b1;
		end
		if (total < -64'sd2147483648) begin
			total = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.value = total[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Offer one item, with a random gap first; the expectation is queued as it is offered.
	task automatic offer_sample(logic signed [31:0] x, bit typed, model_out_t want);
		cfg_we <= 1'b0;
		if (!(sent_count >= 900 && sent_count < 1150) && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_position <= x;
		pending_results.push_back(typed ? want : eval_peak(x));
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	// Lower valid and wait until every expected result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; the caller lowers the write enable with its next item.
	task automatic write_reg(lage_pkg::cfg_reg_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		regs_m[idx] = data;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom;
			4: return 32'($urandom_range(0, 16 << 16)) - 32'(8 << 16);
			default: return 32'($urandom_range(0, 64)) << 12;
		endcase
	endfunction

	function automatic logic [31:0] pick_width();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return -(32'($urandom_range(1, 4 << 16)));
			default: return 32'($urandom_range(1, 4 << 16));
		endcase
	endfunction

	// Positions mostly near one of the peaks, so both terms are exercised.
	function automatic logic [31:0] pick_position();
		case ($urandom_range(9))
			0: return $urandom;
			1: return regs_m[lage_pkg::REG_LORENTZ_CENTER];
			2: return regs_m[lage_pkg::REG_GAUSS_CENTER];
			3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			4, 5: return regs_m[lage_pkg::REG_LORENTZ_CENTER]
				+ 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			default: return regs_m[lage_pkg::REG_GAUSS_CENTER]
				+ 32'($urandom_range(0, 48 << 16)) - 32'(24 << 16);
		endcase
	endfunction

	// Result checker.
	always @(posedge clk) begin
		model_out_t want;
		if (arst_n && out_valid && out_ready) begin
			rx_count++;
			if (saturated)
				sat_count++;
			if (pending_results.size() == 0) begin
				$display("[%0t] result with nothing expected: %h", $time, model_value);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (model_value !== want.value)
					report_mismatch("model_value", model_value, want.value);
				if (saturated !== want.sat)
					report_mismatch("saturated", 32'(saturated), 32'(want.sat));
			end
		end
	end

	// Result receiver: random stalls, one long hold-off, and a calm stretch.
	always @(posedge clk) begin
		int hold_cycles;
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= (hold_cycles == 0);
			end else if (!hold_done && rx_count >= 500) begin
				hold_done = 1'b1;
				hold_cycles = 400;
				out_ready <= 1'b0;
			end else if (rx_count >= 900 && rx_count < 1150) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 18);
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		model_out_t zero_out, none, chk;
		longint unsigned u, term, y;
		longint acc;
		logic [31:0] x;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_position = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lage_pkg::REG_LORENTZ_HEIGHT;
		cfg_wdata = '0;
		error_count = 0;
		sent_count = 0;
		rx_count = 0;
		sat_count = 0;
		gauss_hits = 0;
		hold_done = 1'b0;

		// exp(-16k/depth): series in Q2.30, four squarings, round to Q16.16.
		for (int k = 0; k < lage_pkg::EXP_TABLE_DEPTH; k++) begin
			u = (longint'(k) << 30) / lage_pkg::EXP_TABLE_DEPTH;
			term = 64'd1 << 30;
			acc = longint'(64'd1 << 30);
			for (int i = 1; i <= 14; i++) begin
				term = ((term * u) >> 30) / longint'(i);
				acc = (i % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			y = (acc < 0) ? 64'd0 : longint'(acc);
			repeat (4) y = (y * y + (64'd1 << 29)) >> 30;
			exp_lut[k] = 32'((y + 64'd8192) >> 14);
		end
		regs_m = '{32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000};

		zero_out = '{value: 32'sh0, sat: 1'b0};
		none = zero_out;
		// After reset both heights and the baseline are zero: every result is zero.
		rows.push_back('{ROW_TYPED, lage_pkg::REG_LORENTZ_HEIGHT, 32'h0, zero_out});
		rows.push_back('{ROW_TYPED, lage_pkg::REG_LORENTZ_HEIGHT, 32'h7FFF_FFFF, zero_out});
		rows.push_back('{ROW_TYPED, lage_pkg::REG_LORENTZ_HEIGHT, 32'h8000_0000, zero_out});
		// Zero Lorentz denominator saturates with the sign of the height.
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LORENTZ_WIDTH, 32'h0, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LORENTZ_HEIGHT, -32'sd5, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LORENTZ_CENTER, 32'd100, none});
		rows.push_back('{ROW_TYPED, lage_pkg::REG_LORENTZ_HEIGHT, 32'd100,
			'{value: 32'sh8000_0000, sat: 1'b1}});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LORENTZ_HEIGHT, 32'h7FFF_FFFF, none});
		rows.push_back('{ROW_TYPED, lage_pkg::REG_LORENTZ_HEIGHT, 32'd100,
			'{value: 32'sh7FFF_FFFF, sat: 1'b1}});
		// A huge Lorentz term next to the center is clamped and saturates.
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, 32'd101, none});
		// Denominator beyond 64 bits gives no Lorentz term.
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LORENTZ_CENTER, 32'h8000_0000, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LORENTZ_WIDTH, 32'h8000_0000, none});
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, 32'h7FFF_FFFF, none});
		// Zero right width drops the Gaussian; the left side still has it.
		rows.push_back('{ROW_WRITE, lage_pkg::REG_BASELINE, 32'h7FFF_0000, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_GAUSS_HEIGHT, 32'h7FFF_FFFF, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_GAUSS_CENTER, 32'h0, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_RIGHT_WIDTH, 32'h0, none});
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, 32'd5, none});
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, -32'sd5, none});
		// Tiny sigma puts the argument beyond six, so the Gaussian is zero.
		rows.push_back('{ROW_WRITE, lage_pkg::REG_RIGHT_WIDTH, 32'h1, none});
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, 32'h6_0000, none});
		// Everything at its negative extreme overflows downward.
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LORENTZ_HEIGHT, 32'h8000_0000, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_BASELINE, 32'h8000_0000, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_GAUSS_HEIGHT, 32'h8000_0000, none});
		rows.push_back('{ROW_WRITE, lage_pkg::REG_LEFT_WIDTH, 32'h8000_0000, none});
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, 32'h8000_0001, none});
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, 32'h0, none});
		rows.push_back('{ROW_SAMPLE, lage_pkg::REG_LORENTZ_HEIGHT, -32'sd1, none});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				if (i == 0 || rows[i - 1].kind != ROW_WRITE)
					drain();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				offer_sample(rows[i].data, rows[i].kind == ROW_TYPED, rows[i].want);
			end
		end

		// Random phases: new settings each time, the first two at the extremes.
		for (int phase = 0; phase < 7; phase++) begin
			drain();
			for (int r = 0; r < 8; r++) begin
				if (phase == 0)
					x = 32'h7FFF_FFFF;
				else if (phase == 1)
					x = 32'h8000_0000;
				else if (r == lage_pkg::REG_LORENTZ_WIDTH || r == lage_pkg::REG_RIGHT_WIDTH
						|| r == lage_pkg::REG_LEFT_WIDTH)
					x = pick_width();
				else
					x = pick_word();
				write_reg(lage_pkg::cfg_reg_t'(r), x);
			end
			for (int n = 0; n < 250; n++) begin
				x = pick_position();
				chk = eval_peak(x);
				if (chk.value != regs_m[lage_pkg::REG_BASELINE])
					gauss_hits++;
				offer_sample(x, 1'b0, none);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		$display("Covered %0d items over 7 random register settings, %0d saturated results,",
			sent_count, sat_count);
		$display("%0d results off the baseline, with one long output hold-off.", gauss_hits);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
